### rtl/core/marker_framed_packet_deframer_unit_defines.svh
// ----------------------------------------------------------------------------
// marker_framed_packet_deframer_unit_defines
// assertion macros shared by the deframer rtl
// ----------------------------------------------------------------------------
`ifndef MARKER_FRAMED_PACKET_DEFRAMER_UNIT_DEFINES_SVH
`define MARKER_FRAMED_PACKET_DEFRAMER_UNIT_DEFINES_SVH

// same-cycle implication, sampled on clk, off while rst_n is low
`define MFPD_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, sampled on clk, off while rst_n is low
`define MFPD_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

### rtl/core/mfpd_pkg.sv
// ----------------------------------------------------------------------------
// mfpd_pkg
// shared constants, register codes and control types of the deframer
// ----------------------------------------------------------------------------
package mfpd_pkg;

  localparam int FRAME_BYTES_DEF = 16;
  localparam int BYTE_W          = 8;
  localparam int POS_W           = 4;
  localparam int OUT_TDATA_W     = 16;
  localparam int CFG_IDX_W       = 1;

  localparam logic [BYTE_W-1:0] START_MARKER_RST = 8'h02;
  localparam logic [BYTE_W-1:0] END_MARKER_RST   = 8'h03;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_START_MARKER = 1'b0,
    REG_END_MARKER   = 1'b1
  } cfg_reg_t;

  // controller to datapath
  typedef struct packed {
    logic take;       // input item accepted this cycle
    logic rd_start;   // rewind replay pointer
    logic rd_issue;   // read frame store at replay pointer
    logic rd_next;    // advance replay pointer
    logic load_data;  // put read byte into output register
    logic load_err;   // put error item into output register
  } mfpd_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic close;      // current input byte closes a frame
    logic frame_ok;   // length and checksum of the closing frame pass
    logic rd_last;    // replay pointer is on the closing byte
    logic out_free;   // output register can be loaded this cycle
  } mfpd_sts_t;

endpackage

### rtl/core/mfpd_ctrl.sv
// ----------------------------------------------------------------------------
// mfpd_ctrl
// sequencer: byte intake, frame replay and error item issue
// ----------------------------------------------------------------------------
`include "marker_framed_packet_deframer_unit_defines.svh"

module mfpd_ctrl (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_tvalid,
  output logic               in_tready,
  input  mfpd_pkg::mfpd_sts_t sts,
  output mfpd_pkg::mfpd_cmd_t cmd
);
  import mfpd_pkg::*;

  typedef enum logic [3:0] {
    S_RX   = 4'b0001,
    S_READ = 4'b0010,
    S_LOAD = 4'b0100,
    S_ERR  = 4'b1000
  } state_t;

  state_t state_r, state_nxt;
  logic   take;

  assign in_tready = (state_r == S_RX);
  assign take      = in_tvalid && in_tready;

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    cmd.take  = take;
    unique case (state_r)
      S_RX: begin
        if (take && sts.close) begin
          cmd.rd_start = 1'b1;
          state_nxt    = sts.frame_ok ? S_READ : S_ERR;
        end
      end
      S_READ: begin
        cmd.rd_issue = 1'b1;
        state_nxt    = S_LOAD;
      end
      S_LOAD: begin
        if (sts.out_free) begin
          cmd.load_data = 1'b1;
          if (sts.rd_last) begin
            state_nxt = S_RX;
          end else begin
            cmd.rd_next = 1'b1;
            state_nxt   = S_READ;
          end
        end
      end
      S_ERR: begin
        if (sts.out_free) begin
          cmd.load_err = 1'b1;
          state_nxt    = S_RX;
        end
      end
      default: state_nxt = S_RX;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_RX;
    end else begin
      state_r <= state_nxt;
    end
  end

  `MFPD_ASSERT_NEXT(a_close_leaves_rx, take && sts.close, state_r == S_READ || state_r == S_ERR, "closing byte did not start replay or error issue")
  `MFPD_ASSERT_NOW(a_load_when_free, cmd.load_data || cmd.load_err, sts.out_free, "output register loaded while still occupied")

endmodule

### rtl/core/mfpd_datapath.sv
// ----------------------------------------------------------------------------
// mfpd_datapath
// marker registers, frame store, fill and parity tracking, output register
// ----------------------------------------------------------------------------
`include "marker_framed_packet_deframer_unit_defines.svh"

module mfpd_datapath #(
  parameter int FRAME_BYTES = mfpd_pkg::FRAME_BYTES_DEF
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic [mfpd_pkg::BYTE_W-1:0]      in_byte,
  input  logic                             cfg_we,
  input  mfpd_pkg::cfg_reg_t               cfg_reg,
  input  logic [mfpd_pkg::BYTE_W-1:0]      cfg_wdata,
  input  logic                             out_tready,
  output logic                             out_tvalid,
  output logic [mfpd_pkg::BYTE_W-1:0]      out_byte,
  output logic [mfpd_pkg::POS_W-1:0]       out_pos,
  output logic                             out_last,
  output logic                             out_status,
  input  mfpd_pkg::mfpd_cmd_t              cmd,
  output mfpd_pkg::mfpd_sts_t              sts
);
  import mfpd_pkg::*;

  localparam int AW = $clog2(FRAME_BYTES);
  localparam logic [AW-1:0] LAST_POS = AW'(FRAME_BYTES - 1);
  localparam logic [AW-1:0] MIN_FILL = AW'(2);

  logic [BYTE_W-1:0] start_marker_r, end_marker_r;
  logic [BYTE_W-1:0] frame_mem [FRAME_BYTES];
  logic [BYTE_W-1:0] rdata_r;
  logic [BYTE_W-1:0] parity_r;
  logic [AW-1:0]     fill_r, last_idx_r, rd_idx_r, wr_addr;
  logic              collecting_r;
  logic              is_start, close, mem_we;

  logic              out_valid_r, out_last_r, out_status_r;
  logic [BYTE_W-1:0] out_byte_r;
  logic [POS_W-1:0]  out_pos_r;

  // start marker wins over end marker and over a full buffer
  assign is_start = (in_byte == start_marker_r);
  assign close    = collecting_r && !is_start &&
                    ((in_byte == end_marker_r) || (fill_r == LAST_POS));
  assign wr_addr  = is_start ? '0 : fill_r;
  assign mem_we   = cmd.take && (is_start || collecting_r);

  assign sts.close    = close;
  // parity covers bytes 1..L-2, zero exactly when the checksum matches
  assign sts.frame_ok = (fill_r >= MIN_FILL) && (parity_r == '0);
  assign sts.rd_last  = (rd_idx_r == last_idx_r);
  assign sts.out_free = !out_valid_r || out_tready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      start_marker_r <= START_MARKER_RST;
      end_marker_r   <= END_MARKER_RST;
    end else if (cfg_we) begin
      unique case (cfg_reg)
        REG_START_MARKER: start_marker_r <= cfg_wdata;
        REG_END_MARKER:   end_marker_r   <= cfg_wdata;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      frame_mem[wr_addr] <= in_byte;
    end
    if (cmd.rd_issue) begin
      rdata_r <= frame_mem[rd_idx_r];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fill_r       <= '0;
      collecting_r <= 1'b0;
      parity_r     <= '0;
      last_idx_r   <= '0;
    end else if (cmd.take) begin
      if (is_start) begin
        fill_r       <= AW'(1);
        collecting_r <= 1'b1;
        parity_r     <= '0;
      end else if (close) begin
        last_idx_r   <= fill_r;
        fill_r       <= '0;
        collecting_r <= 1'b0;
        parity_r     <= '0;
      end else if (collecting_r) begin
        fill_r   <= fill_r + AW'(1);
        parity_r <= parity_r ^ in_byte;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rd_idx_r <= '0;
    end else if (cmd.rd_start) begin
      rd_idx_r <= '0;
    end else if (cmd.rd_next) begin
      rd_idx_r <= rd_idx_r + AW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.load_data || cmd.load_err) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_data) begin
      out_byte_r   <= rdata_r;
      out_pos_r    <= POS_W'(rd_idx_r);
      out_last_r   <= sts.rd_last;
      out_status_r <= 1'b0;
    end else if (cmd.load_err) begin
      out_byte_r   <= '0;
      out_pos_r    <= '0;
      out_last_r   <= 1'b1;
      out_status_r <= 1'b1;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_byte   = out_byte_r;
  assign out_pos    = out_pos_r;
  assign out_last   = out_last_r;
  assign out_status = out_status_r;

  `MFPD_ASSERT_NOW(a_idle_fill_zero, !collecting_r, fill_r == '0, "fill count not zero while idle")
  `MFPD_ASSERT_NEXT(a_start_restarts, cmd.take && is_start, collecting_r && fill_r == AW'(1), "start marker did not restart collection")

endmodule

### rtl/core/marker_framed_packet_deframer_unit.sv
// ----------------------------------------------------------------------------
// marker_framed_packet_deframer_unit
// byte stream deframer with start/end markers and xor checksum
// ----------------------------------------------------------------------------
// Takes one received byte per cycle while not replaying. A start-marker byte
// (re)opens a frame; the frame closes on the end marker or on the byte that
// fills the last store position. A closed frame of length L passes when L is
// at least 3 and the xor of bytes 1..L-3 equals byte L-2; it is then replayed
// from the frame store as L items, with tlast on the final one and tuser low.
// A failing frame gives a single item with tuser high, tlast high and zero
// data. After a closing byte, in_tready stays low until the replay is done:
// on a good frame each byte needs one frame store read and one output
// register load, a failing one needs only the error item load, and any
// output side stall holds it longer. The output register lets the next
// byte be taken while a finished item still waits.
module marker_framed_packet_deframer_unit #(
  parameter int FRAME_BYTES = mfpd_pkg::FRAME_BYTES_DEF
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  // input stream
  input  logic                                 in_tvalid,
  output logic                                 in_tready,
  input  logic [mfpd_pkg::BYTE_W-1:0]          in_tdata,   // [7:0] rx_byte
  // result stream
  output logic                                 out_tvalid,
  input  logic                                 out_tready,
  output logic [mfpd_pkg::OUT_TDATA_W-1:0]     out_tdata,  // [7:0] frame_byte,
                                                           // [11:8] byte_position
  output logic                                 out_tlast,  // last
  output logic                                 out_tuser,  // [0] status
  // configuration writes
  input  logic                                 cfg_valid,
  output logic                                 cfg_ready,
  input  logic [mfpd_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [mfpd_pkg::BYTE_W-1:0]          cfg_data
);
  import mfpd_pkg::*;

  mfpd_cmd_t         cmd;
  mfpd_sts_t         sts;
  logic [BYTE_W-1:0] out_byte;
  logic [POS_W-1:0]  out_pos;

  assign cfg_ready = 1'b1;

  mfpd_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .sts       (sts),
    .cmd       (cmd)
  );

  mfpd_datapath #(
    .FRAME_BYTES (FRAME_BYTES)
  ) u_datapath (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_byte    (in_tdata),
    .cfg_we     (cfg_valid && cfg_ready),
    .cfg_reg    (cfg_reg_t'(cfg_index)),
    .cfg_wdata  (cfg_data),
    .out_tready (out_tready),
    .out_tvalid (out_tvalid),
    .out_byte   (out_byte),
    .out_pos    (out_pos),
    .out_last   (out_tlast),
    .out_status (out_tuser),
    .cmd        (cmd),
    .sts        (sts)
  );

  assign out_tdata = {(OUT_TDATA_W - BYTE_W - POS_W)'(0), out_pos, out_byte};

endmodule

### test/marker_framed_packet_deframer_unit_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// marker_framed_packet_deframer_unit_test
// self-checking bench for the marker framed byte deframer
// ----------------------------------------------------------------------------
// Feeds byte streams into the input stream and keeps its own model of frame
// collection, checksum and replay. Every result item is compared field by
// field with the oldest predicted one. Runs default markers, marker extremes,
// equal markers with buffer-full frames, then random frame traffic under
// several marker settings, with random stalls on both sides in some phases.
// ----------------------------------------------------------------------------
module marker_framed_packet_deframer_unit_test;
  import mfpd_pkg::*;

  localparam int   CLK_HALF     = 6;
  localparam int   STORE_DEPTH  = FRAME_BYTES_DEF;
  localparam int   CYCLE_LIMIT  = 400000;
  localparam int   SETTLE       = 4;
  localparam int   TAIL_CYCLES  = 2 * STORE_DEPTH + 8;
  localparam int   RANDOM_ITEMS = 210;
  localparam int   PHASES       = 5;
  localparam int   SHOWN_ERRORS = 10;
  localparam logic STATUS_GOOD  = 1'b0;
  localparam logic STATUS_DROP  = 1'b1;

  typedef struct packed {
    logic [BYTE_W-1:0] data;
    logic [POS_W-1:0]  pos;
    logic              last;
    logic              status;
  } frame_item_t;

  logic                   clk        = 1'b0;
  logic                   rst_n      = 1'b0;
  logic                   in_tvalid  = 1'b0;
  logic                   in_tready;
  logic [BYTE_W-1:0]      in_tdata   = '0;
  logic                   out_tvalid;
  logic                   out_tready = 1'b1;
  logic [OUT_TDATA_W-1:0] out_tdata;
  logic                   out_tlast;
  logic                   out_tuser;
  logic                   cfg_valid  = 1'b0;
  logic                   cfg_ready;
  logic [CFG_IDX_W-1:0]   cfg_index  = '0;
  logic [BYTE_W-1:0]      cfg_data   = '0;

  // frame model state
  logic [BYTE_W-1:0] frame_copy [STORE_DEPTH];
  int unsigned       fill_count  = 0;
  bit                collecting  = 1'b0;
  logic [BYTE_W-1:0] parity      = '0;
  logic [BYTE_W-1:0] start_mk    = START_MARKER_RST;
  logic [BYTE_W-1:0] end_mk      = END_MARKER_RST;
  frame_item_t       replay_q[$];

  int unsigned mismatch_count = 0;
  int unsigned cycle_count    = 0;
  int unsigned stall_cnt      = 0;
  bit          idle_on        = 1'b1;
  frame_item_t want;

  marker_framed_packet_deframer_unit #(
    .FRAME_BYTES(STORE_DEPTH)
  ) i_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .out_tlast (out_tlast),
    .out_tuser (out_tuser),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always #(CLK_HALF) clk = ~clk;

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  // receiver drops out_tready in random bursts while idle_on is set
  always @(posedge clk) begin
    if (!rst_n || !idle_on) begin
      out_tready <= 1'b1;
      stall_cnt  <= 0;
    end else if (stall_cnt != 0) begin
      stall_cnt  <= stall_cnt - 1;
      out_tready <= (stall_cnt == 1);
    end else if ($urandom_range(0, 5) == 0) begin
      stall_cnt  <= $urandom_range(1, 8);
      out_tready <= 1'b0;
    end else begin
      out_tready <= 1'b1;
    end
  end

  task automatic flag_field(input string field, input logic [OUT_TDATA_W-1:0] exp_v,
                            input logic [OUT_TDATA_W-1:0] got_v);
    mismatch_count++;
    if (mismatch_count <= SHOWN_ERRORS)
      $display("deframer: %s expected %0h got %0h (cycle %0d)",
               field, exp_v, got_v, cycle_count);
  endtask

  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) begin
      if (replay_q.size() == 0) begin
        flag_field("unexpected item, tdata", '0, out_tdata);
      end else begin
        want = replay_q.pop_front();
        if (out_tdata[BYTE_W-1:0] !== want.data)
          flag_field("frame_byte", OUT_TDATA_W'(want.data),
                     OUT_TDATA_W'(out_tdata[BYTE_W-1:0]));
        if (out_tdata[BYTE_W+POS_W-1:BYTE_W] !== want.pos)
          flag_field("byte_position", OUT_TDATA_W'(want.pos),
                     OUT_TDATA_W'(out_tdata[BYTE_W+POS_W-1:BYTE_W]));
        if (out_tdata[OUT_TDATA_W-1:BYTE_W+POS_W] !== '0)
          flag_field("tdata padding", '0,
                     OUT_TDATA_W'(out_tdata[OUT_TDATA_W-1:BYTE_W+POS_W]));
        if (out_tlast !== want.last)
          flag_field("last", OUT_TDATA_W'(want.last), OUT_TDATA_W'(out_tlast));
        if (out_tuser !== want.status)
          flag_field("status", OUT_TDATA_W'(want.status), OUT_TDATA_W'(out_tuser));
      end
    end
  end

  // frame collection: works out the replay caused by one received byte
  function automatic void predict_byte(input logic [BYTE_W-1:0] b);
    int unsigned len;
    int unsigned i;
    if (b == start_mk) begin
      frame_copy[0] = b;
      fill_count    = 1;
      collecting    = 1'b1;
      parity        = '0;
      return;
    end
    if (!collecting)
      return;
    if (b != end_mk && fill_count < STORE_DEPTH - 1) begin
      frame_copy[fill_count] = b;
      fill_count++;
      parity ^= b;
      return;
    end
    // closing byte; parity covers bytes 1..L-2 and must cancel out
    frame_copy[fill_count] = b;
    len        = fill_count + 1;
    collecting = 1'b0;
    fill_count = 0;
    if (len < 3 || parity != 0) begin
      replay_q.push_back('{data: '0, pos: '0, last: 1'b1, status: STATUS_DROP});
    end else begin
      for (i = 0; i < len; i++)
        replay_q.push_back('{data: frame_copy[i], pos: POS_W'(i),
                             last: (i == len - 1), status: STATUS_GOOD});
    end
    parity = '0;
  endfunction

  task automatic send_byte(input logic [BYTE_W-1:0] b);
    if (idle_on && $urandom_range(0, 4) == 0) begin
      in_tvalid <= 1'b0;
      repeat ($urandom_range(1, 8)) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= b;
    do @(posedge clk); while (in_tready !== 1'b1);
    predict_byte(b);
  endtask

  task automatic send_list(input logic [BYTE_W-1:0] seq[$]);
    foreach (seq[k]) send_byte(seq[k]);
  endtask

  // stop sending and wait until every predicted item has come out
  task automatic drain(input int unsigned extra);
    in_tvalid <= 1'b0;
    while (replay_q.size() != 0) @(posedge clk);
    repeat (extra) @(posedge clk);
  endtask

  task automatic set_markers(input logic [BYTE_W-1:0] sm, input logic [BYTE_W-1:0] em);
    cfg_valid <= 1'b1;
    cfg_index <= REG_START_MARKER;
    cfg_data  <= sm;
    do @(posedge clk); while (cfg_ready !== 1'b1);
    start_mk = sm;
    cfg_index <= REG_END_MARKER;
    cfg_data  <= em;
    do @(posedge clk); while (cfg_ready !== 1'b1);
    end_mk = em;
    cfg_valid <= 1'b0;
  endtask

  function automatic logic [BYTE_W-1:0] plain_byte();
    logic [BYTE_W-1:0] v;
    do v = BYTE_W'($urandom); while (v == start_mk || v == end_mk);
    return v;
  endfunction

  // one frame with random content; some broken, cut short or pure noise
  task automatic send_random_frame(output int unsigned sent);
    logic [BYTE_W-1:0] body [STORE_DEPTH];
    logic [BYTE_W-1:0] sum;
    int unsigned       len;
    int unsigned       stop;
    int unsigned       kind;
    int unsigned       pick;
    int unsigned       i;
    sent = 0;
    kind = $urandom_range(0, 9);
    if (kind == 9) begin
      stop = $urandom_range(1, 6);
      repeat (stop)
        send_byte(($urandom_range(0, 3) == 0) ? start_mk : BYTE_W'($urandom));
      sent = stop;
      return;
    end
    pick = $urandom_range(0, 9);
    if (start_mk == end_mk || pick == 0) len = STORE_DEPTH;
    else if (pick == 1)                  len = $urandom_range(9, STORE_DEPTH - 1);
    else                                 len = $urandom_range(2, 8);
    body[0] = start_mk;
    sum     = '0;
    for (i = 1; i + 1 < len; i++) begin
      body[i] = plain_byte();
      if (i + 2 < len) sum ^= body[i];
    end
    if (len >= 3 && kind < 7) body[len-2] = sum;
    if (len == STORE_DEPTH && (start_mk == end_mk || $urandom_range(0, 1) == 0))
      body[len-1] = plain_byte();
    else
      body[len-1] = end_mk;
    stop = (kind == 8) ? $urandom_range(1, len - 1) : len;
    for (i = 0; i < stop; i++) send_byte(body[i]);
    sent = stop;
  endtask

  task automatic test_default_markers();
    idle_on = 1'b1;
    send_list({8'h55, 8'h02, 8'h03});                               // stray, then L=2
    send_list({8'h02, 8'h00, 8'h03});                               // shortest good frame
    send_list({8'h02, 8'hAA, 8'h02, 8'hFF, 8'hFF, 8'h00, 8'h03});   // restart mid frame
    send_list({8'h02, 8'h12, 8'h03});                               // checksum fails
  endtask

  task automatic test_marker_extremes();
    logic [BYTE_W-1:0] b;
    logic [BYTE_W-1:0] sum;
    int unsigned       i;
    drain(SETTLE);
    set_markers(8'h00, 8'hFF);
    send_list({8'h00, 8'h81, 8'h81, 8'hFF});
    drain(SETTLE);
    set_markers(8'hFF, 8'h00);
    send_list({8'hFF, 8'h7E, 8'h7E, 8'h00, 8'h00});
    // equal markers: never closes on a marker, only on a full buffer
    drain(SETTLE);
    set_markers(8'hA5, 8'hA5);
    send_byte(8'hA5);
    sum = '0;
    for (i = 1; i < STORE_DEPTH - 2; i++) begin
      b = BYTE_W'(i * 8'h1D);
      sum ^= b;
      send_byte(b);
    end
    send_byte(sum);
    send_byte(8'h3C);
  endtask

  task automatic test_random_frames();
    logic [BYTE_W-1:0] sm;
    int unsigned       total;
    int unsigned       got;
    int unsigned       phase;
    total = 0;
    for (phase = 0; phase < PHASES; phase++) begin
      drain(SETTLE);
      sm = BYTE_W'($urandom);
      case (phase)
        0:       set_markers(START_MARKER_RST, END_MARKER_RST);
        2:       set_markers(sm, sm);
        default: set_markers(sm, BYTE_W'($urandom));
      endcase
      idle_on = (phase != 1 && phase != PHASES - 1);
      while (total < (phase + 1) * RANDOM_ITEMS / PHASES) begin
        send_random_frame(got);
        total += got;
      end
    end
  endtask

  initial begin
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_default_markers();
    test_marker_extremes();
    test_random_frames();
    drain(TAIL_CYCLES);
    mismatch_count += replay_q.size();
    if (mismatch_count == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
